>>> rtl/ntsc_pkg.sv
// Shared types and constants for the normalizing text stream comparator.
// Holds the configuration register indexes, the request and result payload structs, verdict codes and byte codes.
// No dependencies.
package ntsc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLLAPSE_BLANKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_ALL_BLANKS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MERGE_LINE_ENDS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_EMPTY_LINES = 3'd4;

    // Verdict codes
    localparam logic [2:0] VERDICT_CONT      = 3'd0;
    localparam logic [2:0] VERDICT_SAME      = 3'd1;
    localparam logic [2:0] VERDICT_DIFF      = 3'd2;
    localparam logic [2:0] VERDICT_NEED_A    = 3'd3;
    localparam logic [2:0] VERDICT_NEED_B    = 3'd4;
    localparam logic [2:0] VERDICT_NEED_BOTH = 3'd5;

    // Byte codes
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] byte_a;
        logic       have_a;
        logic       done_a;
        logic [7:0] byte_b;
        logic       have_b;
        logic       done_b;
    } item_t;

    typedef struct packed {
        logic       take_a;
        logic       take_b;
        logic [2:0] verdict;
    } result_t;

endpackage

>>> rtl/normalizing_text_stream_compare_top.sv
// Top level of the normalizing text stream comparator.
// Depends on ntsc_pkg for payload types, verdict codes and byte codes.
// The result of each accepted request is loaded into the result register.
// Throughput: one request per cycle while result_ready does not hold back the result; the phase
// walk for a request is one combinational pass from the request port into the result register.
// Reset: rst_n clears all options, the comparison state and the result valid flag.
module normalizing_text_stream_compare_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  ntsc_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ntsc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ntsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic                              cfg_data
);

    typedef enum logic [2:0] {
        PH_ALL   = 3'd0,
        PH_CASE  = 3'd1,
        PH_RUN   = 3'd2,
        PH_EOL_A = 3'd3,
        PH_EOL_B = 3'd4,
        PH_CMP   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        TOK_DONE  = 2'd0,
        TOK_TAKEN = 2'd1,
        TOK_OPEN  = 2'd2,
        TOK_WAIT  = 2'd3
    } tok_code_t;

    typedef struct packed {
        tok_code_t code;
        logic      cr;
        logic      le;
    } tok_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == ntsc_pkg::CHAR_SPACE) || (c == ntsc_pkg::CHAR_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == ntsc_pkg::CHAR_LF) || (c == ntsc_pkg::CHAR_CR);
    endfunction

    // One step of reading a line-end token on one side
    function automatic tok_t token_step(input logic have, input logic done,
                                        input logic [7:0] c, input logic cr,
                                        input logic le);
        tok_t t;
        t.cr   = cr;
        t.le   = le;
        t.code = TOK_WAIT;
        if (cr) begin
            if (have) begin
                t.cr   = 1'b0;
                t.le   = 1'b1;
                t.code = (c == ntsc_pkg::CHAR_LF) ? TOK_TAKEN : TOK_DONE;
            end else if (done) begin
                t.cr   = 1'b0;
                t.le   = 1'b1;
                t.code = TOK_DONE;
            end
        end else if (have) begin
            if (c == ntsc_pkg::CHAR_LF) begin
                t.le   = 1'b1;
                t.code = TOK_TAKEN;
            end else if (c == ntsc_pkg::CHAR_CR) begin
                t.le   = 1'b1;
                t.cr   = 1'b1;
                t.code = TOK_OPEN;
            end else begin
                t.le   = 1'b0;
                t.code = TOK_DONE;
            end
        end else if (done) begin
            t.code = TOK_DONE;
        end
        return t;
    endfunction

    function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
        if (en && c >= ntsc_pkg::CHAR_UPPER_A && c <= ntsc_pkg::CHAR_UPPER_Z)
            return c + ntsc_pkg::CASE_OFFSET;
        return c;
    endfunction

    // Options
    logic fold_case_reg, collapse_blanks_reg, skip_all_blanks_reg;
    logic merge_line_ends_reg, skip_empty_lines_reg;

    // Comparison state
    phase_t phase_reg, phase_next;
    logic   line_start_a_reg, line_start_a_next;
    logic   line_start_b_reg, line_start_b_next;
    logic   blank_run_reg, blank_run_next;
    logic   cr_open_a_reg, cr_open_a_next;
    logic   cr_open_b_reg, cr_open_b_next;
    logic   line_end_a_reg, line_end_a_next;
    logic   line_end_b_reg, line_end_b_next;

    // Result register
    logic              result_valid_reg;
    ntsc_pkg::result_t result_reg, result_next;

    logic item_fire;

    assign item_ready   = !result_valid_reg || result_ready;
    assign item_fire    = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Walk the phases in order for the presented request
    always_comb begin
        logic       ha, hb, da, db, na, nb;
        logic [7:0] a, b, fa, fb;
        logic [2:0] need;
        logic       fin, clear, stall, ca, cb;
        phase_t     ph;
        tok_t       tok;

        a  = item.byte_a;
        b  = item.byte_b;
        ha = item.have_a;
        hb = item.have_b;
        da = item.done_a;
        db = item.done_b;
        na = !ha && !da;
        nb = !hb && !db;
        if (na)
            need = nb ? ntsc_pkg::VERDICT_NEED_BOTH : ntsc_pkg::VERDICT_NEED_A;
        else
            need = nb ? ntsc_pkg::VERDICT_NEED_B : ntsc_pkg::VERDICT_SAME;

        fa    = fold(fold_case_reg, a);
        fb    = fold(fold_case_reg, b);
        fin   = 1'b0;
        clear = 1'b0;
        stall = 1'b0;
        ca    = 1'b0;
        cb    = 1'b0;
        ph    = phase_reg;
        tok   = '{code: TOK_WAIT, cr: 1'b0, le: 1'b0};

        line_start_a_next = line_start_a_reg;
        line_start_b_next = line_start_b_reg;
        blank_run_next    = blank_run_reg;
        cr_open_a_next    = cr_open_a_reg;
        cr_open_b_next    = cr_open_b_reg;
        line_end_a_next   = line_end_a_reg;
        line_end_b_next   = line_end_b_reg;

        result_next.take_a  = 1'b0;
        result_next.take_b  = 1'b0;
        result_next.verdict = ntsc_pkg::VERDICT_CONT;

        // Drop all blanks
        if (!fin && ph == PH_ALL) begin
            if (skip_all_blanks_reg) begin
                ca = ha && is_blank(a);
                cb = hb && is_blank(b);
                if (ca || cb) begin
                    if (ca) line_start_a_next = 1'b0;
                    if (cb) line_start_b_next = 1'b0;
                    result_next.take_a = ca;
                    result_next.take_b = cb;
                    fin = 1'b1;
                end else if (na || nb) begin
                    result_next.verdict = need;
                    fin = 1'b1;
                end
            end
            if (!fin) ph = PH_CASE;
        end

        // Open a blank run
        if (!fin && ph == PH_CASE) begin
            if (collapse_blanks_reg) begin
                ca = 1'b0;
                cb = 1'b0;
                if (ha && is_blank(a)) begin
                    if (hb) begin
                        if (is_blank(b)) begin
                            ca = 1'b1;
                            cb = 1'b1;
                        end else if (is_eol(b)) begin
                            ca = 1'b1;
                        end
                    end else if (!db) begin
                        stall = 1'b1;
                    end else begin
                        ca = 1'b1;
                    end
                end else if (hb && is_blank(b)) begin
                    if (ha) begin
                        if (is_eol(a)) cb = 1'b1;
                    end else if (!da) begin
                        stall = 1'b1;
                    end else begin
                        cb = 1'b1;
                    end
                end
                if (stall) begin
                    result_next.verdict = need;
                    fin = 1'b1;
                end else if (ca || cb) begin
                    blank_run_next = 1'b1;
                    if (ca) line_start_a_next = 1'b0;
                    if (cb) line_start_b_next = 1'b0;
                    ph = PH_RUN;
                    result_next.take_a = ca;
                    result_next.take_b = cb;
                    fin = 1'b1;
                end else begin
                    ph = blank_run_next ? PH_RUN : PH_EOL_A;
                end
            end else begin
                ph = PH_EOL_A;
            end
        end

        // Advance through the rest of a blank run
        if (!fin && ph == PH_RUN) begin
            if (collapse_blanks_reg) begin
                ca = ha && is_blank(a);
                cb = hb && is_blank(b);
                if (ca || cb) begin
                    if (ca) line_start_a_next = 1'b0;
                    if (cb) line_start_b_next = 1'b0;
                    result_next.take_a = ca;
                    result_next.take_b = cb;
                    fin = 1'b1;
                end else if (na || nb) begin
                    blank_run_next = 1'b1;
                    result_next.verdict = need;
                    fin = 1'b1;
                end else begin
                    blank_run_next = 1'b0;
                end
            end
            if (!fin) ph = PH_EOL_A;
        end

        // Line ends on side A, or empty-line skipping on both sides
        if (!fin && ph == PH_EOL_A) begin
            if (skip_empty_lines_reg) begin
                ca = ha && is_eol(a) && (merge_line_ends_reg || line_start_a_next);
                cb = hb && is_eol(b) && (merge_line_ends_reg || line_start_b_next);
                if (ca || cb) begin
                    result_next.take_a = ca;
                    result_next.take_b = cb;
                    fin = 1'b1;
                end else if (na || nb) begin
                    result_next.verdict = need;
                    fin = 1'b1;
                end else begin
                    ph = PH_CMP;
                end
            end else if (merge_line_ends_reg) begin
                tok = token_step(ha, da, a, cr_open_a_next, line_end_a_next);
                cr_open_a_next  = tok.cr;
                line_end_a_next = tok.le;
                if (tok.code == TOK_WAIT) begin
                    result_next.verdict = need;
                    fin = 1'b1;
                end else if (tok.code == TOK_OPEN) begin
                    result_next.take_a = 1'b1;
                    fin = 1'b1;
                end else begin
                    ph = PH_EOL_B;
                    if (tok.code == TOK_TAKEN) begin
                        result_next.take_a = 1'b1;
                        fin = 1'b1;
                    end
                end
            end else begin
                ph = PH_CMP;
            end
        end

        // Line ends on side B
        if (!fin && ph == PH_EOL_B) begin
            if (merge_line_ends_reg && !skip_empty_lines_reg) begin
                tok = token_step(hb, db, b, cr_open_b_next, line_end_b_next);
                cr_open_b_next  = tok.cr;
                line_end_b_next = tok.le;
                if (tok.code == TOK_WAIT) begin
                    result_next.verdict = need;
                    fin = 1'b1;
                end else if (tok.code == TOK_OPEN) begin
                    result_next.take_b = 1'b1;
                    fin = 1'b1;
                end else begin
                    ph = PH_CMP;
                    if (tok.code == TOK_TAKEN) begin
                        result_next.take_b = 1'b1;
                        fin = 1'b1;
                    end
                end
            end else begin
                ph = PH_CMP;
            end
        end

        // Final byte compare
        if (!fin && ph == PH_CMP) begin
            fin = 1'b1;
            if (merge_line_ends_reg && !skip_empty_lines_reg
                && (line_end_a_next != line_end_b_next)) begin
                result_next.verdict = ntsc_pkg::VERDICT_DIFF;
                clear = 1'b1;
            end else if (na || nb) begin
                result_next.verdict = need;
            end else if (!ha || !hb) begin
                result_next.verdict = (ha == hb) ? ntsc_pkg::VERDICT_SAME
                                                 : ntsc_pkg::VERDICT_DIFF;
                clear = 1'b1;
            end else if (fa != fb) begin
                result_next.verdict = ntsc_pkg::VERDICT_DIFF;
                clear = 1'b1;
            end else begin
                line_start_a_next  = is_eol(fa);
                line_start_b_next  = is_eol(fb);
                ph = PH_ALL;
                result_next.take_a = 1'b1;
                result_next.take_b = 1'b1;
            end
        end

        phase_next = ph;

        // Return to the start state after a same or differ verdict
        if (clear) begin
            line_start_a_next = 1'b1;
            line_start_b_next = 1'b1;
            blank_run_next    = 1'b0;
            cr_open_a_next    = 1'b0;
            cr_open_b_next    = 1'b0;
            line_end_a_next   = 1'b0;
            line_end_b_next   = 1'b0;
            phase_next        = PH_ALL;
        end
    end

    // Hold options, state and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_case_reg        <= 1'b0;
            collapse_blanks_reg  <= 1'b0;
            skip_all_blanks_reg  <= 1'b0;
            merge_line_ends_reg  <= 1'b0;
            skip_empty_lines_reg <= 1'b0;
            phase_reg            <= PH_ALL;
            line_start_a_reg     <= 1'b1;
            line_start_b_reg     <= 1'b1;
            blank_run_reg        <= 1'b0;
            cr_open_a_reg        <= 1'b0;
            cr_open_b_reg        <= 1'b0;
            line_end_a_reg       <= 1'b0;
            line_end_b_reg       <= 1'b0;
            result_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ntsc_pkg::CFG_FOLD_CASE:        fold_case_reg        <= cfg_data;
                    ntsc_pkg::CFG_COLLAPSE_BLANKS:  collapse_blanks_reg  <= cfg_data;
                    ntsc_pkg::CFG_SKIP_ALL_BLANKS:  skip_all_blanks_reg  <= cfg_data;
                    ntsc_pkg::CFG_MERGE_LINE_ENDS:  merge_line_ends_reg  <= cfg_data;
                    ntsc_pkg::CFG_SKIP_EMPTY_LINES: skip_empty_lines_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (item_fire)
            begin
                phase_reg        <= phase_next;
                line_start_a_reg <= line_start_a_next;
                line_start_b_reg <= line_start_b_next;
                blank_run_reg    <= blank_run_next;
                cr_open_a_reg    <= cr_open_a_next;
                cr_open_b_reg    <= cr_open_b_next;
                line_end_a_reg   <= line_end_a_next;
                line_end_b_reg   <= line_end_b_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> tb/sv/tb_normalizing_text_stream_compare_top.sv
// Testbench for normalizing_text_stream_compare_top: directed and random text stream pairs.
// Each accepted request is predicted in-bench and checked against the result port.
// Depends on ntsc_pkg and the top level RTL.
module tb_normalizing_text_stream_compare_top;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 15;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int STEP_GUARD      = 150;
    localparam int NUM_OPTIONS     = 5;
    localparam int CFG_W           = ntsc_pkg::CFG_INDEX_W;
    localparam int ITEM_W          = $bits(ntsc_pkg::item_t);
    localparam logic ON  = 1'b1;
    localparam logic OFF = 1'b0;

    // Where the comparison walk stands between requests
    typedef enum logic [2:0] {
        WALK_SKIP_BLANKS,
        WALK_COLLAPSE,
        WALK_RUN,
        WALK_EOL_A,
        WALK_EOL_B,
        WALK_FINAL
    } walk_t;

    // Outcome of reading one line-end token
    typedef enum logic [1:0] {
        TOKEN_DONE,
        TOKEN_TAKEN,
        TOKEN_OPEN,
        TOKEN_WAIT
    } token_t;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    ntsc_pkg::item_t        item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    ntsc_pkg::result_t      result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_index = '0;
    logic                   cfg_data = 1'b0;

    // Option copies and comparison state of the prediction
    logic  opt_fold_case, opt_collapse, opt_skip_blanks, opt_merge_eol, opt_skip_empty;
    logic  cmp_line_start_a, cmp_line_start_b, cmp_blank_run;
    logic  cmp_cr_open_a, cmp_cr_open_b, cmp_line_end_a, cmp_line_end_b;
    walk_t cmp_walk;

    ntsc_pkg::result_t decisions_due[$];
    ntsc_pkg::result_t due_decision;
    int      mismatches = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      rx_left = 0;
    rx_mode_t rx_mode = RX_OPEN;

    normalizing_text_stream_compare_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == ntsc_pkg::CHAR_SPACE || c == ntsc_pkg::CHAR_TAB;
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return c == ntsc_pkg::CHAR_LF || c == ntsc_pkg::CHAR_CR;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c >= ntsc_pkg::CHAR_UPPER_A && c <= ntsc_pkg::CHAR_UPPER_Z;
    endfunction

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (opt_fold_case && is_upper(c))
            return c + ntsc_pkg::CASE_OFFSET;
        return c;
    endfunction

    // Return the comparison state to its start, options untouched
    function automatic void clear_compare();
        cmp_line_start_a = 1'b1;
        cmp_line_start_b = 1'b1;
        cmp_blank_run    = 1'b0;
        cmp_cr_open_a    = 1'b0;
        cmp_cr_open_b    = 1'b0;
        cmp_line_end_a   = 1'b0;
        cmp_line_end_b   = 1'b0;
        cmp_walk         = WALK_SKIP_BLANKS;
    endfunction

    function automatic ntsc_pkg::result_t make_decision(input logic ta, input logic tb,
                                                        input logic [2:0] v);
        ntsc_pkg::result_t r;
        r.take_a  = ta;
        r.take_b  = tb;
        r.verdict = v;
        return r;
    endfunction

    function automatic ntsc_pkg::result_t end_compare(input logic [2:0] v);
        clear_compare();
        return make_decision(OFF, OFF, v);
    endfunction

    // Read one step of a line-end token on one side; a CR may wait for its LF
    function automatic token_t line_token(input logic on_b, input logic have,
                                          input logic done, input logic [7:0] c);
        logic   cr;
        logic   le;
        token_t tok;
        cr = on_b ? cmp_cr_open_b : cmp_cr_open_a;
        le = on_b ? cmp_line_end_b : cmp_line_end_a;
        if (cr)
        begin
            if (have)
            begin
                cr  = 1'b0;
                le  = 1'b1;
                tok = (c == ntsc_pkg::CHAR_LF) ? TOKEN_TAKEN : TOKEN_DONE;
            end
            else if (done)
            begin
                cr  = 1'b0;
                le  = 1'b1;
                tok = TOKEN_DONE;
            end
            else
                tok = TOKEN_WAIT;
        end
        else if (have)
        begin
            if (c == ntsc_pkg::CHAR_LF)
            begin
                le  = 1'b1;
                tok = TOKEN_TAKEN;
            end
            else if (c == ntsc_pkg::CHAR_CR)
            begin
                le  = 1'b1;
                cr  = 1'b1;
                tok = TOKEN_OPEN;
            end
            else
            begin
                le  = 1'b0;
                tok = TOKEN_DONE;
            end
        end
        else
            tok = done ? TOKEN_DONE : TOKEN_WAIT;
        if (on_b)
        begin
            cmp_cr_open_b  = cr;
            cmp_line_end_b = le;
        end
        else
        begin
            cmp_cr_open_a  = cr;
            cmp_line_end_a = le;
        end
        return tok;
    endfunction

    // Walk the option phases for one request and return the decision it causes
    function automatic ntsc_pkg::result_t decide_heads(input ntsc_pkg::item_t req);
        logic       na, nb, ta, tb, stall;
        logic [2:0] need;
        logic [7:0] ca, cb;
        token_t     tok;
        na = !req.have_a && !req.done_a;
        nb = !req.have_b && !req.done_b;
        need = na ? (nb ? ntsc_pkg::VERDICT_NEED_BOTH : ntsc_pkg::VERDICT_NEED_A)
                  : (nb ? ntsc_pkg::VERDICT_NEED_B : ntsc_pkg::VERDICT_SAME);
        for (int hop = 0; hop < 8; hop++)
        begin
            case (cmp_walk)
                WALK_SKIP_BLANKS:
                begin
                    if (opt_skip_blanks)
                    begin
                        ta = req.have_a && is_blank(req.byte_a);
                        tb = req.have_b && is_blank(req.byte_b);
                        if (ta || tb)
                        begin
                            if (ta) cmp_line_start_a = 1'b0;
                            if (tb) cmp_line_start_b = 1'b0;
                            return make_decision(ta, tb, ntsc_pkg::VERDICT_CONT);
                        end
                        if (na || nb)
                            return make_decision(OFF, OFF, need);
                    end
                    cmp_walk = WALK_COLLAPSE;
                end
                WALK_COLLAPSE:
                begin
                    if (opt_collapse)
                    begin
                        stall = 1'b0;
                        ta    = 1'b0;
                        tb    = 1'b0;
                        if (req.have_a && is_blank(req.byte_a))
                        begin
                            if (req.have_b)
                            begin
                                if (is_blank(req.byte_b))
                                begin
                                    ta = 1'b1;
                                    tb = 1'b1;
                                end
                                else if (is_eol(req.byte_b))
                                    ta = 1'b1;
                            end
                            else if (!req.done_b)
                                stall = 1'b1;
                            else
                                ta = 1'b1;
                        end
                        else if (req.have_b && is_blank(req.byte_b))
                        begin
                            if (req.have_a)
                            begin
                                if (is_eol(req.byte_a))
                                    tb = 1'b1;
                            end
                            else if (!req.done_a)
                                stall = 1'b1;
                            else
                                tb = 1'b1;
                        end
                        if (stall)
                            return make_decision(OFF, OFF, need);
                        if (ta || tb)
                        begin
                            cmp_blank_run = 1'b1;
                            if (ta) cmp_line_start_a = 1'b0;
                            if (tb) cmp_line_start_b = 1'b0;
                            cmp_walk = WALK_RUN;
                            return make_decision(ta, tb, ntsc_pkg::VERDICT_CONT);
                        end
                        cmp_walk = cmp_blank_run ? WALK_RUN : WALK_EOL_A;
                    end
                    else
                        cmp_walk = WALK_EOL_A;
                end
                WALK_RUN:
                begin
                    if (opt_collapse)
                    begin
                        ta = req.have_a && is_blank(req.byte_a);
                        tb = req.have_b && is_blank(req.byte_b);
                        if (ta || tb)
                        begin
                            if (ta) cmp_line_start_a = 1'b0;
                            if (tb) cmp_line_start_b = 1'b0;
                            return make_decision(ta, tb, ntsc_pkg::VERDICT_CONT);
                        end
                        if (na || nb)
                        begin
                            cmp_blank_run = 1'b1;
                            return make_decision(OFF, OFF, need);
                        end
                        cmp_blank_run = 1'b0;
                    end
                    cmp_walk = WALK_EOL_A;
                end
                WALK_EOL_A:
                begin
                    if (opt_skip_empty)
                    begin
                        ta = req.have_a && is_eol(req.byte_a)
                             && (opt_merge_eol || cmp_line_start_a);
                        tb = req.have_b && is_eol(req.byte_b)
                             && (opt_merge_eol || cmp_line_start_b);
                        if (ta || tb)
                            return make_decision(ta, tb, ntsc_pkg::VERDICT_CONT);
                        if (na || nb)
                            return make_decision(OFF, OFF, need);
                        cmp_walk = WALK_FINAL;
                    end
                    else if (opt_merge_eol)
                    begin
                        tok = line_token(OFF, req.have_a, req.done_a, req.byte_a);
                        if (tok == TOKEN_WAIT)
                            return make_decision(OFF, OFF, need);
                        if (tok == TOKEN_OPEN)
                            return make_decision(ON, OFF, ntsc_pkg::VERDICT_CONT);
                        cmp_walk = WALK_EOL_B;
                        if (tok == TOKEN_TAKEN)
                            return make_decision(ON, OFF, ntsc_pkg::VERDICT_CONT);
                    end
                    else
                        cmp_walk = WALK_FINAL;
                end
                WALK_EOL_B:
                begin
                    if (opt_merge_eol && !opt_skip_empty)
                    begin
                        tok = line_token(ON, req.have_b, req.done_b, req.byte_b);
                        if (tok == TOKEN_WAIT)
                            return make_decision(OFF, OFF, need);
                        if (tok == TOKEN_OPEN)
                            return make_decision(OFF, ON, ntsc_pkg::VERDICT_CONT);
                        cmp_walk = WALK_FINAL;
                        if (tok == TOKEN_TAKEN)
                            return make_decision(OFF, ON, ntsc_pkg::VERDICT_CONT);
                    end
                    else
                        cmp_walk = WALK_FINAL;
                end
                default:
                begin
                    if (opt_merge_eol && !opt_skip_empty && cmp_line_end_a != cmp_line_end_b)
                        return end_compare(ntsc_pkg::VERDICT_DIFF);
                    if (na || nb)
                        return make_decision(OFF, OFF, need);
                    if (!req.have_a || !req.have_b)
                        return end_compare((req.have_a == req.have_b)
                                           ? ntsc_pkg::VERDICT_SAME
                                           : ntsc_pkg::VERDICT_DIFF);
                    ca = fold_byte(req.byte_a);
                    cb = fold_byte(req.byte_b);
                    if (ca != cb)
                        return end_compare(ntsc_pkg::VERDICT_DIFF);
                    cmp_line_start_a = is_eol(ca);
                    cmp_line_start_b = is_eol(cb);
                    cmp_walk = WALK_SKIP_BLANKS;
                    return make_decision(ON, ON, ntsc_pkg::VERDICT_CONT);
                end
            endcase
        end
        return make_decision(OFF, OFF, ntsc_pkg::VERDICT_CONT);
    endfunction

    // Run timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result port in segments of random pattern and length
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   result_ready <= 1'b1;
            RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
            default:   result_ready <= ~result_ready;
        endcase
    end

    // Check each accepted result against the oldest pending decision
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (decisions_due.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %b",
                         $time, result);
                mismatches++;
            end
            else
            begin
                due_decision = decisions_due.pop_front();
                if (result.take_a !== due_decision.take_a)
                begin
                    $display("%0t: take_a expected %0b, actual %0b",
                             $time, due_decision.take_a, result.take_a);
                    mismatches++;
                end
                if (result.take_b !== due_decision.take_b)
                begin
                    $display("%0t: take_b expected %0b, actual %0b",
                             $time, due_decision.take_b, result.take_b);
                    mismatches++;
                end
                if (result.verdict !== due_decision.verdict)
                begin
                    $display("%0t: verdict expected %0d, actual %0d",
                             $time, due_decision.verdict, result.verdict);
                    mismatches++;
                end
            end
        end
    end

    // Send one request in bursts with random gaps; predict it once accepted
    task automatic send_item(input ntsc_pkg::item_t req, output ntsc_pkg::result_t predicted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
        item       <= req;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        predicted = decide_heads(req);
        decisions_due.push_back(predicted);
    endtask

    // Drop valid and wait until every pending decision has come back
    task automatic drain_requests();
        item_valid <= 1'b0;
        @(posedge clk);
        while (decisions_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_option(input logic [CFG_W-1:0] idx, input logic value);
        drain_requests();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ntsc_pkg::CFG_FOLD_CASE:        opt_fold_case   = value;
            ntsc_pkg::CFG_COLLAPSE_BLANKS:  opt_collapse    = value;
            ntsc_pkg::CFG_SKIP_ALL_BLANKS:  opt_skip_blanks = value;
            ntsc_pkg::CFG_MERGE_LINE_ENDS:  opt_merge_eol   = value;
            ntsc_pkg::CFG_SKIP_EMPTY_LINES: opt_skip_empty  = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic present(input logic [7:0] a, input logic ha, input logic da,
                           input logic [7:0] b, input logic hb, input logic db);
        ntsc_pkg::item_t   req;
        ntsc_pkg::result_t ignored;
        req.byte_a = a;
        req.have_a = ha;
        req.done_a = da;
        req.byte_b = b;
        req.have_b = hb;
        req.done_b = db;
        send_item(req, ignored);
    endtask

    // End of file, starvation, byte extremes, have and done together
    task automatic test_end_of_file();
        present(8'h00, OFF, ON, 8'h00, OFF, ON);
        present(8'h78, ON, OFF, 8'h00, OFF, ON);
        present(8'h00, OFF, OFF, 8'h00, OFF, OFF);
        present(8'h00, OFF, OFF, 8'h78, ON, OFF);
        present(8'h78, ON, OFF, 8'h00, OFF, OFF);
        present(8'h00, ON, ON, 8'h00, ON, ON);
        present(8'hFF, ON, OFF, 8'hFF, ON, OFF);
        present(8'hFF, ON, OFF, 8'h7F, ON, OFF);
    endtask

    // Case folding at the letter boundaries
    task automatic test_fold_case();
        write_option(ntsc_pkg::CFG_FOLD_CASE, ON);
        present(ntsc_pkg::CHAR_UPPER_A, ON, OFF, 8'h61, ON, OFF);
        present(8'h7A, ON, OFF, ntsc_pkg::CHAR_UPPER_Z, ON, OFF);
        present(8'h40, ON, OFF, 8'h60, ON, OFF);
        write_option(ntsc_pkg::CFG_FOLD_CASE, OFF);
    endtask

    // Blank runs facing blanks, bytes, line ends, starvation and end of file; then skipping all blanks
    task automatic test_blank_options();
        write_option(ntsc_pkg::CFG_COLLAPSE_BLANKS, ON);
        present(ntsc_pkg::CHAR_SPACE, ON, OFF, ntsc_pkg::CHAR_TAB, ON, OFF);
        present(ntsc_pkg::CHAR_SPACE, ON, OFF, 8'h6B, ON, OFF);
        present(8'h6B, ON, OFF, 8'h6B, ON, OFF);
        present(ntsc_pkg::CHAR_SPACE, ON, OFF, ntsc_pkg::CHAR_LF, ON, OFF);
        present(ntsc_pkg::CHAR_SPACE, ON, OFF, 8'h00, OFF, OFF);
        present(ntsc_pkg::CHAR_SPACE, ON, OFF, 8'h00, OFF, ON);
        present(8'h00, OFF, ON, 8'h00, OFF, ON);
        write_option(ntsc_pkg::CFG_COLLAPSE_BLANKS, OFF);
        write_option(ntsc_pkg::CFG_SKIP_ALL_BLANKS, ON);
        present(ntsc_pkg::CHAR_TAB, ON, OFF, 8'h71, ON, OFF);
        write_option(ntsc_pkg::CFG_SKIP_ALL_BLANKS, OFF);
    endtask

    // CR/LF split across requests, then empty lines skipped
    task automatic test_line_ends();
        write_option(ntsc_pkg::CFG_MERGE_LINE_ENDS, ON);
        present(ntsc_pkg::CHAR_CR, ON, OFF, ntsc_pkg::CHAR_LF, ON, OFF);
        present(8'h00, OFF, OFF, ntsc_pkg::CHAR_LF, ON, OFF);
        present(ntsc_pkg::CHAR_LF, ON, OFF, ntsc_pkg::CHAR_LF, ON, OFF);
        present(8'h78, ON, OFF, ntsc_pkg::CHAR_LF, ON, OFF);
        write_option(ntsc_pkg::CFG_SKIP_EMPTY_LINES, ON);
        present(ntsc_pkg::CHAR_LF, ON, OFF, 8'h78, ON, OFF);
        write_option(ntsc_pkg::CFG_MERGE_LINE_ENDS, OFF);
        write_option(ntsc_pkg::CFG_SKIP_EMPTY_LINES, OFF);
    endtask

    // Writes past the last register must change nothing
    task automatic test_unused_index();
        for (int idx = NUM_OPTIONS; idx < (1 << CFG_W); idx++)
            write_option(CFG_W'(idx), ON);
        present(ntsc_pkg::CHAR_UPPER_A, ON, OFF, 8'h61, ON, OFF);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0, 1:    return ntsc_pkg::CHAR_SPACE;
            2:       return ntsc_pkg::CHAR_TAB;
            3:       return ntsc_pkg::CHAR_LF;
            4:       return ntsc_pkg::CHAR_CR;
            5:       return 8'($urandom);
            6, 7:    return ntsc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
            8, 9:    return ntsc_pkg::CHAR_UPPER_A + ntsc_pkg::CASE_OFFSET
                            + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // Present one side's head: a byte, no byte yet, or end of file
    task automatic head_of(input logic [7:0] text[$], input int pos,
                           output logic [7:0] b, output logic h, output logic d);
        b = 8'($urandom);
        h = 1'b0;
        d = 1'b0;
        if ($urandom_range(0, 7) == 0)
            return;
        if (pos < text.size())
        begin
            b = text[pos];
            h = 1'b1;
            d = ($urandom_range(0, 15) == 0);
        end
        else
            d = 1'b1;
    endtask

    // Pairs of similar texts streamed head by head under a range of option settings
    task automatic test_random_streams();
        logic [7:0] text_a[$];
        logic [7:0] text_b[$];
        logic [7:0] spare[$];
        logic [7:0] c;
        logic [4:0] opts;
        logic       noise;
        int         pos_a, pos_b, steps, sent, len;
        ntsc_pkg::item_t   req;
        ntsc_pkg::result_t predicted;
        steps = STEP_GUARD;
        pos_a = 0;
        pos_b = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            opts = (phase == 0) ? 5'b00000 : (phase == 1) ? 5'b11111 : 5'($urandom);
            write_option(ntsc_pkg::CFG_FOLD_CASE,        opts[0]);
            write_option(ntsc_pkg::CFG_COLLAPSE_BLANKS,  opts[1]);
            write_option(ntsc_pkg::CFG_SKIP_ALL_BLANKS,  opts[2]);
            write_option(ntsc_pkg::CFG_MERGE_LINE_ENDS,  opts[3]);
            write_option(ntsc_pkg::CFG_SKIP_EMPTY_LINES, opts[4]);
            if ($urandom_range(0, 3) == 0)
                write_option(CFG_W'($urandom_range(NUM_OPTIONS, (1 << CFG_W) - 1)),
                             1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // Start a new text pair once the last one is decided or abandoned
                if (steps >= STEP_GUARD)
                begin
                    text_a.delete();
                    text_b.delete();
                    len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
                    repeat (len) text_a.push_back(pick_char());
                    if ($urandom_range(0, 2) == 0)
                        text_b = text_a;
                    else
                    begin
                        foreach (text_a[i])
                        begin
                            c = text_a[i];
                            case ($urandom_range(0, 24))
                                0:
                                begin
                                    if (is_upper(c) || is_upper(c ^ ntsc_pkg::CASE_OFFSET))
                                        text_b.push_back(c ^ ntsc_pkg::CASE_OFFSET);
                                    else
                                        text_b.push_back(c);
                                end
                                1:
                                begin
                                    text_b.push_back(c);
                                    text_b.push_back(ntsc_pkg::CHAR_SPACE);
                                end
                                2:
                                begin
                                    text_b.push_back(ntsc_pkg::CHAR_TAB);
                                    text_b.push_back(c);
                                end
                                3:
                                begin
                                    if (!is_blank(c))
                                        text_b.push_back(c);
                                end
                                4:
                                begin
                                    if (c == ntsc_pkg::CHAR_LF)
                                    begin
                                        text_b.push_back(ntsc_pkg::CHAR_CR);
                                        text_b.push_back(ntsc_pkg::CHAR_LF);
                                    end
                                    else if (c == ntsc_pkg::CHAR_CR)
                                        text_b.push_back(ntsc_pkg::CHAR_LF);
                                    else
                                        text_b.push_back(c);
                                end
                                5:
                                begin
                                    text_b.push_back(c);
                                    text_b.push_back(ntsc_pkg::CHAR_LF);
                                end
                                6:       text_b.push_back(pick_char());
                                7:       ;
                                default: text_b.push_back(c);
                            endcase
                        end
                        if ($urandom_range(0, 3) == 0)
                            text_b.push_back(($urandom_range(0, 1) == 0)
                                             ? ntsc_pkg::CHAR_SPACE
                                             : ntsc_pkg::CHAR_LF);
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        spare  = text_a;
                        text_a = text_b;
                        text_b = spare;
                    end
                    pos_a = 0;
                    pos_b = 0;
                    steps = 0;
                end
                noise = ($urandom_range(0, 9) == 0);
                if (noise)
                    req = ntsc_pkg::item_t'(ITEM_W'($urandom));
                else
                begin
                    head_of(text_a, pos_a, req.byte_a, req.have_a, req.done_a);
                    head_of(text_b, pos_b, req.byte_b, req.have_b, req.done_b);
                end
                send_item(req, predicted);
                sent++;
                steps++;
                // Advance the streams by what the block takes
                if (!noise)
                begin
                    if (predicted.take_a) pos_a++;
                    if (predicted.take_b) pos_b++;
                end
                if (predicted.verdict == ntsc_pkg::VERDICT_SAME
                    || predicted.verdict == ntsc_pkg::VERDICT_DIFF)
                    steps = STEP_GUARD;
            end
        end
    endtask

    initial
    begin
        opt_fold_case   = 1'b0;
        opt_collapse    = 1'b0;
        opt_skip_blanks = 1'b0;
        opt_merge_eol   = 1'b0;
        opt_skip_empty  = 1'b0;
        clear_compare();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_end_of_file();
        test_fold_case();
        test_blank_options();
        test_line_ends();
        test_unused_index();
        test_random_streams();
        drain_requests();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && decisions_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
